// ===== design/tdl_pkg.sv =====
// Shared types, codes and lookup functions for the table-driven lexer step.
// No dependencies; used by tdl_core, tdl_out_queue and table_driven_lexer_step.
`timescale 1ns / 1ps

package tdl_pkg;

    // One input word: a source byte and the start-of-text flag.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_begin;
    } t_in_word;

    // One result word: a token or an error report.
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_out_word;

    // Results produced by one accepted byte, handed from the core to the queue.
    typedef struct packed {
        logic [1:0] count;
        t_out_word  first;
        t_out_word  second;
    } t_push;

    typedef enum logic [7:0] {
        ST_START   = 8'b0000_0001,
        ST_MACRO   = 8'b0000_0010,
        ST_LITERAL = 8'b0000_0100,
        ST_SYMBOL  = 8'b0000_1000,
        ST_STRING  = 8'b0001_0000,
        ST_ESCAPE  = 8'b0010_0000,
        ST_NUMBER  = 8'b0100_0000,
        ST_BAD     = 8'b1000_0000
    } t_scan_state;

    typedef enum logic [3:0] {
        CL_LETTER  = 4'd0,
        CL_HASH    = 4'd1,
        CL_SPACE   = 4'd2,
        CL_SYMBOL  = 4'd3,
        CL_DOT     = 4'd4,
        CL_NEWLINE = 4'd5,
        CL_DIGIT   = 4'd6,
        CL_QUOTE   = 4'd7,
        CL_BSLASH  = 4'd8,
        CL_NONE    = 4'd9
    } t_char_class;

    localparam logic [3:0] KIND_NONE    = 4'd0;
    localparam logic [3:0] KIND_MACRO   = 4'd0;
    localparam logic [3:0] KIND_LITERAL = 4'd1;
    localparam logic [3:0] KIND_NUMBER  = 4'd2;
    localparam logic [3:0] KIND_STRING  = 4'd3;
    localparam logic [3:0] KIND_LPAREN  = 4'd4;
    localparam logic [3:0] KIND_RPAREN  = 4'd5;
    localparam logic [3:0] KIND_LBRACE  = 4'd6;
    localparam logic [3:0] KIND_RBRACE  = 4'd7;
    localparam logic [3:0] KIND_SEMI    = 4'd8;
    localparam logic [3:0] KIND_RETURN  = 4'd9;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_UNCLASSED = 3'd1;
    localparam logic [2:0] ERR_FORBIDDEN = 3'd2;
    localparam logic [2:0] ERR_NO_KIND   = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

    localparam logic [2:0] KEYWORD_LEN = 3'd6;

    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class cls;
        if (c == 8'h23) cls = CL_HASH;
        else if (c == 8'h20) cls = CL_SPACE;
        else if (c == 8'h2E) cls = CL_DOT;
        else if (c == 8'h0A) cls = CL_NEWLINE;
        else if (c == 8'h22) cls = CL_QUOTE;
        else if (c == 8'h5C) cls = CL_BSLASH;
        else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) cls = CL_LETTER;
        else if (c >= 8'h30 && c <= 8'h39) cls = CL_DIGIT;
        else if (c == 8'h3C || c == 8'h3E || c == 8'h28 || c == 8'h29 ||
                 c == 8'h7B || c == 8'h7D || c == 8'h2C || c == 8'h3B) cls = CL_SYMBOL;
        else cls = CL_NONE;
        return cls;
    endfunction

    // Bracket or semicolon kind; KIND_NONE for the other symbols.
    function automatic logic [3:0] symbol_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h3B:   k = KIND_SEMI;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Characters of the keyword "return".
    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h75;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Transition table of the scanner.
    function automatic t_scan_state scan_transition(input t_scan_state st,
                                                    input t_char_class cls);
        t_scan_state nx;
        nx = ST_BAD;
        case (st)
            ST_START: begin
                case (cls)
                    CL_LETTER:  nx = ST_LITERAL;
                    CL_HASH:    nx = ST_MACRO;
                    CL_SPACE:   nx = ST_START;
                    CL_SYMBOL:  nx = ST_SYMBOL;
                    CL_NEWLINE: nx = ST_START;
                    CL_DIGIT:   nx = ST_NUMBER;
                    default:    nx = ST_BAD;
                endcase
            end
            ST_MACRO: begin
                case (cls)
                    CL_LETTER:  nx = ST_MACRO;
                    CL_SPACE:   nx = ST_MACRO;
                    CL_SYMBOL:  nx = ST_MACRO;
                    CL_DOT:     nx = ST_MACRO;
                    CL_NEWLINE: nx = ST_START;
                    default:    nx = ST_BAD;
                endcase
            end
            ST_LITERAL: begin
                case (cls)
                    CL_LETTER: nx = ST_LITERAL;
                    CL_SPACE:  nx = ST_START;
                    CL_SYMBOL: nx = ST_SYMBOL;
                    CL_DIGIT:  nx = ST_LITERAL;
                    default:   nx = ST_BAD;
                endcase
            end
            ST_SYMBOL: begin
                case (cls)
                    CL_SPACE:   nx = ST_START;
                    CL_SYMBOL:  nx = ST_SYMBOL;
                    CL_NEWLINE: nx = ST_START;
                    CL_QUOTE:   nx = ST_STRING;
                    default:    nx = ST_BAD;
                endcase
            end
            ST_STRING: begin
                case (cls)
                    CL_LETTER: nx = ST_STRING;
                    CL_SPACE:  nx = ST_STRING;
                    CL_SYMBOL: nx = ST_STRING;
                    CL_QUOTE:  nx = ST_START;
                    CL_BSLASH: nx = ST_ESCAPE;
                    default:   nx = ST_BAD;
                endcase
            end
            ST_ESCAPE: begin
                case (cls)
                    CL_LETTER: nx = ST_STRING;
                    default:   nx = ST_BAD;
                endcase
            end
            ST_NUMBER: begin
                case (cls)
                    CL_SYMBOL: nx = ST_SYMBOL;
                    default:   nx = ST_BAD;
                endcase
            end
            default: nx = ST_BAD;
        endcase
        return nx;
    endfunction

endpackage

// ===== design/tdl_core.sv =====
// Scanner state and per-byte result forming for the lexer step.
// Depends on tdl_pkg; instantiated by table_driven_lexer_step.
`timescale 1ns / 1ps

module tdl_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  tdl_pkg::t_in_word i_word,
    output tdl_pkg::t_push    o_push
);

    localparam int PW = POSITION_BITS + 1;

    tdl_pkg::t_scan_state     r_state, n_state, cur_state;
    logic                     r_pending, n_pending, cur_pending;
    logic [POSITION_BITS-1:0] r_start, n_start, cur_start;
    logic [POSITION_BITS-1:0] r_end, n_end, cur_end;
    logic [PW-1:0]            r_pos, n_pos, cur_pos;
    logic [2:0]               r_kw_matched, n_kw_matched, cur_kw_matched;
    logic                     r_kw_failed, n_kw_failed, cur_kw_failed;
    logic                     r_halted, n_halted, cur_halted;

    tdl_pkg::t_char_class     cls;
    tdl_pkg::t_scan_state     nx;
    logic [7:0]               c;
    logic [3:0]               sym;
    logic                     kw_hit;
    logic [POSITION_BITS-1:0] emit_end;
    logic [PW-1:0]            emit_len;
    logic [32:0]              emit_len_ext;
    logic [32:0]              start_ext;
    logic [32:0]              pos_ext;
    logic [3:0]               pend_kind;
    tdl_pkg::t_out_word       pend_word;
    tdl_pkg::t_out_word       err_word;
    tdl_pkg::t_out_word       sym_word;

    // A byte with text_begin sees the reset state.
    always_comb begin
        if (i_word.text_begin) begin
            cur_state      = tdl_pkg::ST_START;
            cur_pending    = 1'b0;
            cur_start      = '0;
            cur_end        = '0;
            cur_pos        = '0;
            cur_kw_matched = '0;
            cur_kw_failed  = 1'b0;
            cur_halted     = 1'b0;
        end else begin
            cur_state      = r_state;
            cur_pending    = r_pending;
            cur_start      = r_start;
            cur_end        = r_end;
            cur_pos        = r_pos;
            cur_kw_matched = r_kw_matched;
            cur_kw_failed  = r_kw_failed;
            cur_halted     = r_halted;
        end
    end

    assign c    = i_word.text_byte;
    assign cls  = tdl_pkg::classify(c);
    assign nx   = tdl_pkg::scan_transition(cur_state, cls);
    assign sym  = tdl_pkg::symbol_kind(c);

    assign kw_hit = !cur_kw_failed && (cur_kw_matched < tdl_pkg::KEYWORD_LEN) &&
                    (c == tdl_pkg::keyword_char(cur_kw_matched));

    // A closing quote belongs to the string token.
    assign emit_end     = (cur_state == tdl_pkg::ST_STRING) ?
                          cur_pos[POSITION_BITS-1:0] : cur_end;
    assign emit_len     = {1'b0, emit_end} - {1'b0, cur_start} + PW'(1);
    assign emit_len_ext = 33'(emit_len);
    assign start_ext    = 33'(cur_start);
    assign pos_ext      = 33'(cur_pos);

    always_comb begin
        case (cur_state)
            tdl_pkg::ST_MACRO:   pend_kind = tdl_pkg::KIND_MACRO;
            tdl_pkg::ST_LITERAL: pend_kind = (!cur_kw_failed &&
                                              cur_kw_matched == tdl_pkg::KEYWORD_LEN) ?
                                             tdl_pkg::KIND_RETURN : tdl_pkg::KIND_LITERAL;
            tdl_pkg::ST_NUMBER:  pend_kind = tdl_pkg::KIND_NUMBER;
            default:             pend_kind = tdl_pkg::KIND_STRING;
        endcase
    end

    always_comb begin
        pend_word.token_kind   = pend_kind;
        pend_word.token_start  = start_ext[15:0];
        pend_word.token_length = (emit_len_ext > 33'd65535) ? 16'hFFFF : emit_len_ext[15:0];
        pend_word.error_code   = tdl_pkg::ERR_OK;
        pend_word.last_of_run  = 1'b0;

        sym_word.token_kind    = sym;
        sym_word.token_start   = pos_ext[15:0];
        sym_word.token_length  = 16'd1;
        sym_word.error_code    = tdl_pkg::ERR_OK;
        sym_word.last_of_run   = 1'b1;

        err_word.token_kind    = tdl_pkg::KIND_MACRO;
        err_word.token_start   = pos_ext[15:0];
        err_word.token_length  = 16'd0;
        err_word.error_code    = tdl_pkg::ERR_OK;
        err_word.last_of_run   = 1'b1;
        if (cur_pos[POSITION_BITS]) begin
            err_word.error_code = tdl_pkg::ERR_TOO_LONG;
        end else if (cls == tdl_pkg::CL_NONE) begin
            err_word.error_code = tdl_pkg::ERR_UNCLASSED;
        end else if (nx == tdl_pkg::ST_BAD) begin
            err_word.error_code = tdl_pkg::ERR_FORBIDDEN;
        end else begin
            err_word.error_code = tdl_pkg::ERR_NO_KIND;
        end
    end

    always_comb begin
        n_state      = cur_state;
        n_pending    = cur_pending;
        n_start      = cur_start;
        n_end        = cur_end;
        n_pos        = cur_pos;
        n_kw_matched = cur_kw_matched;
        n_kw_failed  = cur_kw_failed;
        n_halted     = cur_halted;

        o_push.count  = 2'd0;
        o_push.first  = err_word;
        o_push.second = err_word;

        if (cur_halted) begin
            // Halted bytes are swallowed without results.
        end else if (cur_pos[POSITION_BITS] || cls == tdl_pkg::CL_NONE ||
                     nx == tdl_pkg::ST_BAD) begin
            o_push.count = 2'd1;
            n_halted     = 1'b1;
        end else begin
            if (nx == tdl_pkg::ST_START) begin
                if (cur_pending) begin
                    o_push.count = 2'd1;
                    o_push.first = pend_word;
                    o_push.first.last_of_run = 1'b1;
                    n_pending = 1'b0;
                    n_end     = emit_end;
                end
            end else if (nx == tdl_pkg::ST_SYMBOL) begin
                if (cur_pending) begin
                    o_push.count  = 2'd2;
                    o_push.first  = pend_word;
                    o_push.second = (sym == tdl_pkg::KIND_NONE) ? err_word : sym_word;
                    n_pending     = 1'b0;
                end else begin
                    o_push.count = 2'd1;
                    o_push.first = (sym == tdl_pkg::KIND_NONE) ? err_word : sym_word;
                end
            end else if (cur_pending) begin
                n_end = cur_pos[POSITION_BITS-1:0];
                if (kw_hit) begin
                    n_kw_matched = cur_kw_matched + 3'd1;
                end else begin
                    n_kw_failed = 1'b1;
                end
            end else begin
                n_pending = 1'b1;
                n_start   = cur_pos[POSITION_BITS-1:0];
                n_end     = cur_pos[POSITION_BITS-1:0];
                // A new token begins its keyword match from scratch.
                if (c == tdl_pkg::keyword_char(3'd0)) begin
                    n_kw_matched = 3'd1;
                    n_kw_failed  = 1'b0;
                end else begin
                    n_kw_matched = 3'd0;
                    n_kw_failed  = 1'b1;
                end
            end

            if (nx == tdl_pkg::ST_SYMBOL && sym == tdl_pkg::KIND_NONE) begin
                // The state and position stay where they were.
                n_halted = 1'b1;
            end else begin
                n_state = nx;
                n_pos   = cur_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tdl_pkg::ST_START;
            r_pending    <= 1'b0;
            r_start      <= '0;
            r_end        <= '0;
            r_pos        <= '0;
            r_kw_matched <= '0;
            r_kw_failed  <= 1'b0;
            r_halted     <= 1'b0;
        end else if (i_accept) begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_start      <= n_start;
            r_end        <= n_end;
            r_pos        <= n_pos;
            r_kw_matched <= n_kw_matched;
            r_kw_failed  <= n_kw_failed;
            r_halted     <= n_halted;
        end
    end

endmodule

// ===== design/tdl_out_queue.sv =====
// Four-entry result queue that takes up to two words per cycle and sends one.
// Depends on tdl_pkg; instantiated by table_driven_lexer_step.
`timescale 1ns / 1ps

module tdl_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_en,
    input  tdl_pkg::t_push     i_push,
    input  logic               i_ready,
    output logic               o_valid,
    output tdl_pkg::t_out_word o_word,
    output logic               o_room2
);

    tdl_pkg::t_out_word r_mem [4];
    logic [1:0]         r_wr_ptr, n_wr_ptr;
    logic [1:0]         r_rd_ptr, n_rd_ptr;
    logic [2:0]         r_count, n_count;
    logic [1:0]         push_n;
    logic               pop;

    assign push_n  = i_push_en ? i_push.count : 2'd0;
    assign o_valid = (r_count != 3'd0);
    assign o_word  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // Two free words are needed before a byte can be taken.
    assign o_room2 = (r_count <= 3'd2);

    assign n_wr_ptr = r_wr_ptr + push_n;
    assign n_rd_ptr = r_rd_ptr + {1'b0, pop};
    assign n_count  = r_count + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/table_driven_lexer_step.sv =====
// Table-driven lexer step: byte-serial tokenizer for a small C-like language.
// Input channel: one word per byte (text_byte, text_begin) on i_in_valid / o_in_ready.
// Output channel: token or error words on o_out_valid / i_out_ready; each byte gives
// zero, one or two words, the last of them flagged with last_of_run.
// The words caused by a byte are registered in the result queue when the byte is
// accepted; a second word follows in the cycle after the first one is taken.
// Throughput: one byte per cycle while o_in_ready is high, set by the combinational
// classify, table lookup and counter update in tdl_core; the output port sends one
// word per cycle, so two-word bytes lower the sustained rate to match the output.
// The four-word result queue keeps taking bytes while a result waits; o_in_ready
// drops only when fewer than two queue entries are free, so a stalled receiver
// fills the queue and then holds the input side.
// After an error word the scanner halts and drops bytes until one with text_begin.
// Reset (i_rst_n low, synchronous) empties the queue and puts the scanner at the
// start state with position 0 and no open token.
// Depends on tdl_pkg, tdl_core and tdl_out_queue.
`timescale 1ns / 1ps

module table_driven_lexer_step #(
    parameter int POSITION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tdl_pkg::t_in_word  i_in_data,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output tdl_pkg::t_out_word o_out_data,
    input  logic               i_out_ready
);

    logic           in_accept;
    logic           room2;
    tdl_pkg::t_push push;

    assign o_in_ready = room2;
    assign in_accept  = i_in_valid && room2;

    tdl_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_data),
        .o_push   (push)
    );

    tdl_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (in_accept),
        .i_push    (push),
        .i_ready   (i_out_ready),
        .o_valid   (o_out_valid),
        .o_word    (o_out_data),
        .o_room2   (room2)
    );

endmodule

// ===== sim/table_driven_lexer_step_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for table_driven_lexer_step: directed and random source texts.
// A scoreboard class predicts the token and error words. Depends on tdl_pkg and the block.

module table_driven_lexer_step_tb;

    localparam int POSITION_BITS  = 16;
    localparam int POS_SPAN       = 1 << POSITION_BITS;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    class lexer_scoreboard;
        tdl_pkg::t_out_word   expected_words[$];
        int                   error_count;
        int                   word_count;
        int                   report_limit = 100;
        string                kw_text = "return";
        tdl_pkg::t_scan_state scan;
        bit                   open_tok;
        logic [31:0]          tok_first;
        logic [31:0]          tok_last;
        logic [31:0]          next_pos;
        logic [2:0]           kw_hits;
        bit                   kw_miss;
        bit                   stopped;

        function new();
            error_count = 0;
            word_count  = 0;
            restart();
        endfunction

        function void restart();
            scan      = tdl_pkg::ST_START;
            open_tok  = 1'b0;
            tok_first = '0;
            tok_last  = '0;
            next_pos  = '0;
            kw_hits   = '0;
            kw_miss   = 1'b0;
            stopped   = 1'b0;
        endfunction

        function tdl_pkg::t_char_class byte_class(logic [7:0] c);
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return tdl_pkg::CL_LETTER;
            if (c >= "0" && c <= "9") return tdl_pkg::CL_DIGIT;
            case (c)
                "#":                                return tdl_pkg::CL_HASH;
                " ":                                return tdl_pkg::CL_SPACE;
                ".":                                return tdl_pkg::CL_DOT;
                8'h0A:                              return tdl_pkg::CL_NEWLINE;
                8'h22:                              return tdl_pkg::CL_QUOTE;
                8'h5C:                              return tdl_pkg::CL_BSLASH;
                "<", ">", "(", ")", "{", "}", ",", ";": return tdl_pkg::CL_SYMBOL;
                default:                            return tdl_pkg::CL_NONE;
            endcase
        endfunction

        function tdl_pkg::t_scan_state scan_next(tdl_pkg::t_scan_state st,
                                                 tdl_pkg::t_char_class cls);
            case (st)
                tdl_pkg::ST_START: begin
                    if (cls == tdl_pkg::CL_LETTER) return tdl_pkg::ST_LITERAL;
                    if (cls == tdl_pkg::CL_HASH) return tdl_pkg::ST_MACRO;
                    if (cls == tdl_pkg::CL_SPACE || cls == tdl_pkg::CL_NEWLINE)
                        return tdl_pkg::ST_START;
                    if (cls == tdl_pkg::CL_SYMBOL) return tdl_pkg::ST_SYMBOL;
                    if (cls == tdl_pkg::CL_DIGIT) return tdl_pkg::ST_NUMBER;
                end
                tdl_pkg::ST_MACRO: begin
                    if (cls == tdl_pkg::CL_NEWLINE) return tdl_pkg::ST_START;
                    if (cls == tdl_pkg::CL_LETTER || cls == tdl_pkg::CL_SPACE ||
                        cls == tdl_pkg::CL_SYMBOL || cls == tdl_pkg::CL_DOT)
                        return tdl_pkg::ST_MACRO;
                end
                tdl_pkg::ST_LITERAL: begin
                    if (cls == tdl_pkg::CL_LETTER || cls == tdl_pkg::CL_DIGIT)
                        return tdl_pkg::ST_LITERAL;
                    if (cls == tdl_pkg::CL_SPACE) return tdl_pkg::ST_START;
                    if (cls == tdl_pkg::CL_SYMBOL) return tdl_pkg::ST_SYMBOL;
                end
                tdl_pkg::ST_SYMBOL: begin
                    if (cls == tdl_pkg::CL_SPACE || cls == tdl_pkg::CL_NEWLINE)
                        return tdl_pkg::ST_START;
                    if (cls == tdl_pkg::CL_SYMBOL) return tdl_pkg::ST_SYMBOL;
                    if (cls == tdl_pkg::CL_QUOTE) return tdl_pkg::ST_STRING;
                end
                tdl_pkg::ST_STRING: begin
                    if (cls == tdl_pkg::CL_LETTER || cls == tdl_pkg::CL_SPACE ||
                        cls == tdl_pkg::CL_SYMBOL)
                        return tdl_pkg::ST_STRING;
                    if (cls == tdl_pkg::CL_QUOTE) return tdl_pkg::ST_START;
                    if (cls == tdl_pkg::CL_BSLASH) return tdl_pkg::ST_ESCAPE;
                end
                tdl_pkg::ST_ESCAPE: begin
                    if (cls == tdl_pkg::CL_LETTER) return tdl_pkg::ST_STRING;
                end
                tdl_pkg::ST_NUMBER: begin
                    if (cls == tdl_pkg::CL_SYMBOL) return tdl_pkg::ST_SYMBOL;
                end
                default: ;
            endcase
            return tdl_pkg::ST_BAD;
        endfunction

        function logic [3:0] bracket_kind(logic [7:0] c);
            case (c)
                "(":     return tdl_pkg::KIND_LPAREN;
                ")":     return tdl_pkg::KIND_RPAREN;
                "{":     return tdl_pkg::KIND_LBRACE;
                "}":     return tdl_pkg::KIND_RBRACE;
                ";":     return tdl_pkg::KIND_SEMI;
                default: return tdl_pkg::KIND_NONE;
            endcase
        endfunction

        function tdl_pkg::t_out_word make_word(logic [3:0] kind, logic [31:0] start,
                                               logic [31:0] len, logic [2:0] err);
            tdl_pkg::t_out_word w;
            w.token_kind   = kind;
            w.token_start  = start[15:0];
            w.token_length = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
            w.error_code   = err;
            w.last_of_run  = 1'b0;
            return w;
        endfunction

        function tdl_pkg::t_out_word open_word();
            logic [3:0] kind;
            case (scan)
                tdl_pkg::ST_MACRO:   kind = tdl_pkg::KIND_MACRO;
                tdl_pkg::ST_LITERAL: kind = (!kw_miss && kw_hits == tdl_pkg::KEYWORD_LEN) ?
                                            tdl_pkg::KIND_RETURN : tdl_pkg::KIND_LITERAL;
                tdl_pkg::ST_NUMBER:  kind = tdl_pkg::KIND_NUMBER;
                default:             kind = tdl_pkg::KIND_STRING;
            endcase
            return make_word(kind, tok_first, tok_last - tok_first + 1, tdl_pkg::ERR_OK);
        endfunction

        function void track_keyword(logic [7:0] c);
            if (!kw_miss && kw_hits < tdl_pkg::KEYWORD_LEN && c == kw_text[kw_hits])
                kw_hits++;
            else
                kw_miss = 1'b1;
        endfunction

        // Returns 1 when the byte reached the scanner, 0 when a halted scanner dropped it.
        function bit note_byte(tdl_pkg::t_in_word w);
            tdl_pkg::t_out_word   fresh[$];
            logic [7:0]           c;
            logic [31:0]          p;
            tdl_pkg::t_char_class cls;
            tdl_pkg::t_scan_state nx;
            logic [3:0]           kind;
            c = w.text_byte;
            if (w.text_begin) restart();
            if (stopped) return 1'b0;
            p   = next_pos;
            cls = byte_class(c);
            nx  = (cls == tdl_pkg::CL_NONE) ? tdl_pkg::ST_BAD : scan_next(scan, cls);
            if (p >= POS_SPAN) begin
                fresh.push_back(make_word(tdl_pkg::KIND_NONE, p, 0, tdl_pkg::ERR_TOO_LONG));
            end else if (cls == tdl_pkg::CL_NONE) begin
                fresh.push_back(make_word(tdl_pkg::KIND_NONE, p, 0, tdl_pkg::ERR_UNCLASSED));
            end else if (nx == tdl_pkg::ST_BAD) begin
                fresh.push_back(make_word(tdl_pkg::KIND_NONE, p, 0, tdl_pkg::ERR_FORBIDDEN));
            end else begin
                if (nx == tdl_pkg::ST_START) begin
                    if (open_tok) begin
                        // The closing quote belongs to the string.
                        if (scan == tdl_pkg::ST_STRING) tok_last = p;
                        fresh.push_back(open_word());
                        open_tok = 1'b0;
                    end
                end else if (nx == tdl_pkg::ST_SYMBOL) begin
                    if (open_tok) begin
                        fresh.push_back(open_word());
                        open_tok = 1'b0;
                    end
                    kind = bracket_kind(c);
                    if (kind == tdl_pkg::KIND_NONE)
                        fresh.push_back(make_word(tdl_pkg::KIND_NONE, p, 0,
                                                  tdl_pkg::ERR_NO_KIND));
                    else
                        fresh.push_back(make_word(kind, p, 1, tdl_pkg::ERR_OK));
                end else if (open_tok) begin
                    tok_last = p;
                    track_keyword(c);
                end else begin
                    open_tok  = 1'b1;
                    tok_first = p;
                    tok_last  = p;
                    kw_hits   = '0;
                    kw_miss   = 1'b0;
                    track_keyword(c);
                end
                scan     = nx;
                next_pos = p + 1;
            end
            if (fresh.size() > 0) begin
                if (fresh[fresh.size() - 1].error_code != tdl_pkg::ERR_OK) stopped = 1'b1;
                fresh[fresh.size() - 1].last_of_run = 1'b1;
            end
            foreach (fresh[i]) expected_words.push_back(fresh[i]);
            return 1'b1;
        endfunction

        task report(string msg);
            error_count++;
            // Keep the log short when the block is badly off; every mismatch still counts.
            if (error_count <= report_limit) $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("word %0d %s got %0d expected %0d", word_count, name, got, want));
        endtask

        task check_word(tdl_pkg::t_out_word got);
            tdl_pkg::t_out_word want;
            word_count++;
            if (expected_words.size() == 0) begin
                report($sformatf("word %0d arrived with nothing expected", word_count));
                return;
            end
            want = expected_words.pop_front();
            compare_field("token_kind", 16'(got.token_kind), 16'(want.token_kind));
            compare_field("token_start", got.token_start, want.token_start);
            compare_field("token_length", got.token_length, want.token_length);
            compare_field("error_code", 16'(got.error_code), 16'(want.error_code));
            compare_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    tdl_pkg::t_in_word  i_in_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    tdl_pkg::t_out_word o_out_data;
    logic               i_out_ready = 1'b0;

    lexer_scoreboard board = new();
    logic [7:0]      text_buf[$];
    bit              no_idle = 1'b0;
    bit              hold_req = 1'b0;
    int              hold_count = 0;
    int              live_items = 0;
    int              random_start = 0;
    int              holds_issued = 0;
    int              quiet_cycles = 0;

    table_driven_lexer_step #(
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_ready(i_out_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle || hold_req) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] any_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] any_symbol();
        string kinded = "(){};";
        string kindless = "<>,";
        if ($urandom_range(0, 24) == 0) return kindless[$urandom_range(0, 2)];
        return kinded[$urandom_range(0, 4)];
    endfunction

    function automatic logic [7:0] macro_char();
        case ($urandom_range(0, 5))
            0:       return " ";
            1:       return ".";
            2:       return any_symbol();
            default: return any_letter();
        endcase
    endfunction

    task automatic load_str(string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic load_kw(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic add_literal();
        string near_kw[5] = '{"return", "returns", "retur", "xreturn", "returnreturn"};
        int n;
        if ($urandom_range(0, 2) == 0) begin
            load_kw(near_kw[$urandom_range(0, 4)]);
        end else begin
            text_buf.push_back(any_letter());
            n = $urandom_range(0, 7);
            repeat (n) text_buf.push_back(($urandom_range(0, 3) == 0) ?
                                          8'("0" + $urandom_range(0, 9)) : any_letter());
        end
    endtask

    // A random text made mostly of well-formed tokens, sometimes cut short or spoiled.
    task automatic build_text();
        int target;
        int n;
        bit at_symbol;
        text_buf.delete();
        target    = $urandom_range(6, 60);
        at_symbol = 1'b0;
        while (text_buf.size() < target) begin
            if (!at_symbol) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        add_literal();
                        if ($urandom_range(0, 1)) begin
                            text_buf.push_back(" ");
                        end else begin
                            text_buf.push_back(any_symbol());
                            at_symbol = 1'b1;
                        end
                    end
                    3: begin
                        text_buf.push_back(8'("0" + $urandom_range(0, 9)));
                        text_buf.push_back(any_symbol());
                        at_symbol = 1'b1;
                    end
                    4: begin
                        text_buf.push_back("#");
                        n = $urandom_range(0, 8);
                        repeat (n) text_buf.push_back(macro_char());
                        text_buf.push_back(8'h0A);
                    end
                    5: text_buf.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
                    default: begin
                        text_buf.push_back(any_symbol());
                        at_symbol = 1'b1;
                    end
                endcase
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        text_buf.push_back(8'h22);
                        n = $urandom_range(0, 8);
                        repeat (n) begin
                            case ($urandom_range(0, 5))
                                0: text_buf.push_back(" ");
                                1: text_buf.push_back(any_symbol());
                                2: begin
                                    text_buf.push_back(8'h5C);
                                    text_buf.push_back(any_letter());
                                end
                                default: text_buf.push_back(any_letter());
                            endcase
                        end
                        text_buf.push_back(8'h22);
                        at_symbol = 1'b0;
                    end
                    2: text_buf.push_back(any_symbol());
                    default: begin
                        text_buf.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
                        at_symbol = 1'b0;
                    end
                endcase
            end
        end
        // A cut text leaves its last token open when the next text begins.
        if ($urandom_range(0, 3) == 0)
            while (text_buf.size() > target) void'(text_buf.pop_back());
        if ($urandom_range(0, 6) == 0)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic send_byte(logic [7:0] b, bit first);
        tdl_pkg::t_in_word w;
        int gap;
        w.text_byte  = b;
        w.text_begin = first;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (board.note_byte(w)) live_items++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_byte(text_buf[i], i == 0);
    endtask

    // Result side: random ready pattern, and a long hold-off on request.
    initial begin
        int stretch;
        int gap;
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                hold_count++;
            end else begin
                stretch = $urandom_range(1, 24);
                i_out_ready <= 1'b1;
                repeat (stretch) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_word(o_out_data);
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Keyword, then a literal left open when the next text begins.
        load_str("return( x");
        send_text();
        // Longer literal is not the keyword; a kindless symbol halts, the last byte is dropped.
        load_str("returns,z");
        send_text();
        load_str("#a\n7;");
        send_text();
        // Empty string, then a string with an escape.
        load_str("(\"\"{\"\\q\"");
        send_text();
        text_buf = '{8'h00};
        send_text();
        text_buf = '{8'hFF};
        send_text();
        load_str("\"");
        send_text();

        random_start = live_items;
        while (live_items - random_start < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if (holds_issued < 2 && live_items - random_start > 400 + 500 * holds_issued) begin
                hold_req = 1'b1;
                holds_issued++;
            end
            build_text();
            send_text();
        end
        i_in_valid <= 1'b0;

        while (board.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d scanned bytes and %0d result words over directed and",
                 live_items, board.word_count);
        $display("random texts with errors, halts and %0d long result-side hold-offs.",
                 hold_count);
        if (board.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tdl_pkg.sv
design/tdl_core.sv
design/tdl_out_queue.sv
design/table_driven_lexer_step.sv
sim/table_driven_lexer_step_tb.sv
